// ----- hdl/plwe_pkg.sv -----
// shared types, constants and helpers for the power limit word encoder
// no dependencies
package plwe_pkg;

  localparam int unsigned DIVIDEND_W  = 32;
  localparam int unsigned PREM_W      = 10;   // power unit is at most 1000
  localparam int unsigned TREM_W      = 20;   // time unit is at most 1000000
  localparam int unsigned STEP_BITS_D = 4;    // quotient bits per divider stage
  localparam int unsigned CFG_W       = 15;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWR_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_EXP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TSP      = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_BAD_ARGS    = 2'd2;

  localparam logic [6:0]  DEFAULT_WINDOW = 7'h6E;
  localparam logic [3:0]  PWR_EXP_MAX    = 4'd9;
  localparam logic [9:0]  MW_BASE        = 10'd1000;
  localparam logic [19:0] US_BASE        = 20'd1000000;

  typedef struct packed {
    logic        mw_zero;
    logic        us_zero;
    logic        clamp;
    logic        enable;
    logic [63:0] cur;
  } plwe_side_t;

  function automatic logic [PREM_W-1:0] power_unit(input logic [3:0] e);
    logic [3:0] s;
    s = (e > PWR_EXP_MAX) ? PWR_EXP_MAX : e;
    return MW_BASE >> s;
  endfunction

  function automatic logic [TREM_W-1:0] window_divisor(input logic [3:0] e);
    return US_BASE >> e;
  endfunction

  function automatic logic [4:0] floor_log2(input logic [DIVIDEND_W-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 1; i < DIVIDEND_W; i++) begin
      if (v[i]) n = i[4:0];
    end
    return n;
  endfunction

endpackage

// ----- hdl/plwe_div_stage.sv -----
// one registered stage of the two restoring dividers (power and time lanes)
// depends on plwe_pkg
module plwe_div_stage #(
  parameter int unsigned STEP_BITS = plwe_pkg::STEP_BITS_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            vld_in,
  input  logic [plwe_pkg::DIVIDEND_W-1:0] pq_in,
  input  logic [plwe_pkg::PREM_W-1:0]     pr_in,
  input  logic [plwe_pkg::DIVIDEND_W-1:0] tq_in,
  input  logic [plwe_pkg::TREM_W-1:0]     tr_in,
  input  plwe_pkg::plwe_side_t            side_in,
  input  logic [plwe_pkg::PREM_W-1:0]     pdiv,
  input  logic [plwe_pkg::TREM_W-1:0]     tdiv,
  output logic                            vld_r,
  output logic [plwe_pkg::DIVIDEND_W-1:0] pq_r,
  output logic [plwe_pkg::PREM_W-1:0]     pr_r,
  output logic [plwe_pkg::DIVIDEND_W-1:0] tq_r,
  output logic [plwe_pkg::TREM_W-1:0]     tr_r,
  output plwe_pkg::plwe_side_t            side_r
);
  import plwe_pkg::*;

  logic [DIVIDEND_W-1:0] pq_nxt, tq_nxt;
  logic [PREM_W-1:0]     pr_nxt;
  logic [TREM_W-1:0]     tr_nxt;

  always_comb begin
    logic [PREM_W:0] pw;
    logic [TREM_W:0] tw;
    pq_nxt = pq_in;
    pr_nxt = pr_in;
    tq_nxt = tq_in;
    tr_nxt = tr_in;
    for (int i = 0; i < STEP_BITS; i++) begin
      pw     = {pr_nxt, pq_nxt[DIVIDEND_W-1]};
      pq_nxt = {pq_nxt[DIVIDEND_W-2:0], 1'b0};
      if (pw >= {1'b0, pdiv}) begin
        pw        = pw - {1'b0, pdiv};
        pq_nxt[0] = 1'b1;
      end
      pr_nxt = pw[PREM_W-1:0];
      tw     = {tr_nxt, tq_nxt[DIVIDEND_W-1]};
      tq_nxt = {tq_nxt[DIVIDEND_W-2:0], 1'b0};
      if (tw >= {1'b0, tdiv}) begin
        tw        = tw - {1'b0, tdiv};
        tq_nxt[0] = 1'b1;
      end
      tr_nxt = tw[TREM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pq_r   <= pq_nxt;
      pr_r   <= pr_nxt;
      tq_r   <= tq_nxt;
      tr_r   <= tr_nxt;
      side_r <= side_in;
    end
  end

endmodule

// ----- hdl/plwe_encode.sv -----
// two registered stages that range check the power quotient, encode the window
// and assemble the limit word; depends on plwe_pkg
module plwe_encode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            vld_in,
  input  logic [plwe_pkg::DIVIDEND_W-1:0] pq,
  input  logic [plwe_pkg::DIVIDEND_W-1:0] tq,
  input  plwe_pkg::plwe_side_t            side_in,
  input  logic                            feature,
  input  logic [14:0]                     tsp,
  output logic                            vld_r,
  output logic [63:0]                     word_r,
  output logic [1:0]                      status_r
);
  import plwe_pkg::*;

  logic                  v1_r;
  logic [14:0]           pf_r, pf_nxt;
  logic                  bad_r, bad_nxt;
  logic [DIVIDEND_W-1:0] tq1_r;
  logic [4:0]            y_r, y_nxt;
  plwe_side_t            side1_r;
  logic [63:0]           word_nxt;
  logic [1:0]            status_nxt;

  assign pf_nxt  = side_in.mw_zero ? tsp : pq[14:0];
  assign bad_nxt = !side_in.mw_zero && (pq[DIVIDEND_W-1:15] != '0);
  assign y_nxt   = floor_log2(tq);

  always_comb begin
    logic [DIVIDEND_W+1:0] sh;
    logic [6:0]            win;
    sh  = {tq1_r, 2'b00} >> y_r;
    win = side1_r.us_zero ? DEFAULT_WINDOW : {sh[1:0], y_r};
    word_nxt        = side1_r.cur;
    word_nxt[14:0]  = pf_r;
    word_nxt[15]    = side1_r.enable;
    word_nxt[16]    = side1_r.clamp;
    word_nxt[23:17] = win;
    status_nxt      = ST_OK;
    if (!feature) begin
      word_nxt   = side1_r.cur;
      status_nxt = ST_UNSUPPORTED;
    end else if (bad_r) begin
      word_nxt   = side1_r.cur;
      status_nxt = ST_BAD_ARGS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= vld_in;
      vld_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pf_r     <= pf_nxt;
      bad_r    <= bad_nxt;
      tq1_r    <= tq;
      y_r      <= y_nxt;
      side1_r  <= side_in;
      word_r   <= word_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ----- hdl/power_limit_word_encoder_top.sv -----
// top level of the package long-term power limit word encoder
// depends on plwe_pkg, plwe_div_stage and plwe_encode
//
// usage
//   in_* carries one request: a power limit in mW, a window in us, clamp and
//   enable requests and the present 64-bit limit word
//   out_* returns the updated word and a status (ok, not supported, bad args)
//   cfg_* writes the four unit and feature registers; user must do so while the block is idle (unchecked)
// timing
//   a fully pipelined block: one request per cycle sustained unless the output stalls
//   the pipe has 32/STEP_BITS divider stages plus two encode stages, with a
//   default of four quotient bits per stage
//   the depth is set by the two restoring dividers (power and time lanes)
//   running side by side, STEP_BITS compare and subtract steps per stage
// reset
//   rst_n low clears every valid bit and loads the register defaults
// stalls
//   when out_tready is low with a result waiting, the whole pipeline holds and
//   in_tready drops; nothing is lost or repeated
module power_limit_word_encoder_top #(
  parameter int unsigned STEP_BITS = plwe_pkg::STEP_BITS_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // power_limit_mw[31:0], time_window_us[63:32], clamp_request[64],
  // enable_request[65], current_limit_word[129:66], zero pad to 136
  input  logic [135:0]                   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // new_limit_word[63:0], status[65:64], zero pad to 72
  output logic [71:0]                    out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [plwe_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [plwe_pkg::CFG_W-1:0]     cfg_wdata
);
  import plwe_pkg::*;

  localparam int unsigned NSTAGE = DIVIDEND_W / STEP_BITS;

  // configuration registers
  logic        feature_r;
  logic [3:0]  pexp_r;
  logic [3:0]  texp_r;
  logic [14:0] tsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_r <= 1'b1;
      pexp_r    <= 4'd3;
      texp_r    <= 4'd10;
      tsp_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_FEATURE:  feature_r <= cfg_wdata[0];
        CFG_PWR_EXP:  pexp_r    <= cfg_wdata[3:0];
        CFG_TIME_EXP: texp_r    <= cfg_wdata[3:0];
        CFG_TSP:      tsp_r     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // divisors follow the registers, which the user must hold still while requests are in flight (not enforced)
  logic [PREM_W-1:0] pdiv;
  logic [TREM_W-1:0] tdiv;
  assign pdiv = power_unit(pexp_r);
  assign tdiv = window_divisor(texp_r);

  // one enable for the whole pipe: move unless a result is stuck at the output
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  plwe_side_t side_in;
  assign side_in.mw_zero = (in_tdata[31:0] == '0);
  assign side_in.us_zero = (in_tdata[63:32] == '0);
  assign side_in.clamp   = in_tdata[64];
  assign side_in.enable  = in_tdata[65];
  assign side_in.cur     = in_tdata[129:66];

  logic                  vld  [NSTAGE+1];
  logic [DIVIDEND_W-1:0] pq   [NSTAGE+1];
  logic [PREM_W-1:0]     pr   [NSTAGE+1];
  logic [DIVIDEND_W-1:0] tq   [NSTAGE+1];
  logic [TREM_W-1:0]     tr   [NSTAGE+1];
  plwe_side_t            side [NSTAGE+1];

  // dividend enters the quotient register, remainders start at zero
  assign vld[0]  = in_tvalid;
  assign pq[0]   = in_tdata[31:0];
  assign pr[0]   = '0;
  assign tq[0]   = in_tdata[63:32];
  assign tr[0]   = '0;
  assign side[0] = side_in;

  for (genvar g = 0; g < NSTAGE; g++) begin : g_div
    plwe_div_stage #(.STEP_BITS(STEP_BITS)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (vld[g]),
      .pq_in   (pq[g]),
      .pr_in   (pr[g]),
      .tq_in   (tq[g]),
      .tr_in   (tr[g]),
      .side_in (side[g]),
      .pdiv    (pdiv),
      .tdiv    (tdiv),
      .vld_r   (vld[g+1]),
      .pq_r    (pq[g+1]),
      .pr_r    (pr[g+1]),
      .tq_r    (tq[g+1]),
      .tr_r    (tr[g+1]),
      .side_r  (side[g+1])
    );
  end

  logic [63:0] word;
  logic [1:0]  status;

  // the final remainders are not needed; the encoder takes the quotients only
  plwe_encode u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .vld_in   (vld[NSTAGE]),
    .pq       (pq[NSTAGE]),
    .tq       (tq[NSTAGE]),
    .side_in  (side[NSTAGE]),
    .feature  (feature_r),
    .tsp      (tsp_r),
    .vld_r    (out_tvalid),
    .word_r   (word),
    .status_r (status)
  );

  assign out_tdata = {6'b0, status, word};

endmodule

// ----- hdl/plwe_checker.sv -----
// port level checks for the power limit word encoder, bound to the top level
// depends on power_limit_word_encoder_top
module plwe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // a held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // input side is open exactly when the output can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  // status code is never the unused value
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:64] != 2'b11))
    else $error("illegal status");

  // nothing is offered straight after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind power_limit_word_encoder_top plwe_checker u_plwe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/tb_top.sv -----
// testbench for the power limit word encoder: directed and random requests
// depends on plwe_pkg and power_limit_word_encoder_top; scoreboard predicts each word
module tb_top;
  import plwe_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] word;
  } limit_result_t;

  // scoreboard: predicts the updated limit word from the register copy
  class limit_word_board;
    logic        feat;
    logic [3:0]  pexp_r;
    logic [3:0]  texp_r;
    logic [14:0] tsp;
    limit_result_t pending[$];
    int mismatches;

    function void reset_regs();
      feat = 1'b1; pexp_r = 4'd3; texp_r = 4'd10; tsp = '0;
      pending.delete(); mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        CFG_FEATURE:  feat = val[0];
        CFG_PWR_EXP:  pexp_r = val[3:0];
        CFG_TIME_EXP: texp_r = val[3:0];
        default:      tsp = val;
      endcase
    endfunction

    function void note_request(logic [31:0] mw, logic [31:0] us, logic cl, logic en,
                               logic [63:0] cur);
      limit_result_t r;
      logic [63:0] w, raw, q, pu, tu;
      int y;
      logic [63:0] z;
      r.word = cur;
      r.status = ST_OK;
      w = cur;
      if (!feat) begin
        r.status = ST_UNSUPPORTED;
        pending.push_back(r);
        return;
      end
      pu = 64'd1000 >> ((pexp_r > 4'd9) ? 4'd9 : pexp_r);
      tu = 64'd1000000 >> texp_r;
      w[14:0] = '0;
      if (mw != 0) begin
        raw = {32'd0, mw} / pu;
        if (raw > 64'h7FFF) begin
          r.status = ST_BAD_ARGS;
          pending.push_back(r);
          return;
        end
        w[14:0] = raw[14:0];
      end else w[14:0] = tsp;
      if (us != 0) begin
        q = {32'd0, us} / tu;
        y = 0; z = 0;
        if (q != 0) begin
          for (int i = 0; i < 64; i++) if (q[i]) y = i;
          z = ((q << 2) >> y) - 64'd4;
        end
        w[21:17] = y[4:0];
        w[23:22] = z[1:0];
      end else w[23:17] = 7'h6E;
      w[16] = cl;
      w[15] = en;
      r.word = w;
      pending.push_back(r);
    endfunction

    function void check_result(limit_result_t got);
      limit_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.word !== exp_r.word || got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected word %h status %0d, got word %h status %0d",
                   exp_r.word, exp_r.status, got.word, got.status);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [135:0] in_tdata;
  logic [71:0] out_tdata;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  limit_word_board board;
  int idle_cycles;

  power_limit_word_encoder_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // one register write, made while the block is idle
  task automatic write_cfg(logic [1:0] idx, logic [14:0] val);
    cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // send one request after a random gap, note it when accepted
  task automatic send_request(logic [31:0] mw, logic [31:0] us, logic cl, logic en,
                              logic [63:0] cur);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, cur, en, cl, us, mw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(mw, us, cl, en, cur);
  endtask

  // wait for every prediction to be matched, then for the pipeline to drain
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return $urandom_range(1, 40);
      2: return $urandom >> $urandom_range(0, 31);
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls, checks each result
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_result(out_tdata[65:0]);
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [14:0] tsp_vals[4];
    board = new();
    board.reset_regs();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero requests, overflow, short window
    send_request(32'd0, 32'd0, 1'b0, 1'b0, 64'd0);
    send_request(32'd0, 32'd0, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'h5A5A_A5A5_0F0F_F0F0);
    send_request(32'd4095, 32'd1, 1'b0, 1'b1, 64'h1234_5678_9ABC_DEF0);
    send_request(32'd4096, 32'd977, 1'b1, 1'b1, 64'd0);
    send_request(32'd1, 32'd976, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(32'd125, 32'd7000, 1'b1, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();
    write_cfg(CFG_TSP, 15'h7FFF);
    write_cfg(CFG_PWR_EXP, 15'd15);
    write_cfg(CFG_TIME_EXP, 15'd0);
    send_request(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'd0);
    send_request(32'd32767, 32'd999_999, 1'b0, 1'b1, 64'd0);
    send_request(32'd32768, 32'd1_000_000, 1'b1, 1'b0, 64'd0);
    drain();
    write_cfg(CFG_FEATURE, 15'd0);
    send_request(32'd10, 32'd10, 1'b1, 1'b1, 64'hDEAD_BEEF_0000_1111);
    send_request(32'd0, 32'd0, 1'b0, 1'b0, 64'h0);
    drain();
    write_cfg(CFG_FEATURE, 15'd1);
    write_cfg(CFG_PWR_EXP, 15'd0);
    write_cfg(CFG_TIME_EXP, 15'd15);
    send_request(32'd32_767_999, 32'd30, 1'b1, 1'b1, 64'd0);
    send_request(32'd32_768_000, 32'd31, 1'b0, 1'b0, 64'd0);
    drain();

    // random phases, each with its own register setting
    tsp_vals = '{15'd0, 15'h7FFF, 15'h2AAA, 15'h5555};
    for (int ph = 0; ph < 16; ph++) begin
      write_cfg(CFG_FEATURE, 15'($urandom_range(0, 5) != 0));
      write_cfg(CFG_PWR_EXP, 15'($urandom_range(0, 15)));
      write_cfg(CFG_TIME_EXP, 15'($urandom_range(0, 15)));
      write_cfg(CFG_TSP, (ph < 4) ? tsp_vals[ph] : 15'($urandom));
      for (int i = 0; i < 100; i++) begin
        send_request(rand_field(), rand_field(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), {$urandom, $urandom});
      end
      drain();
    end

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
